FILE: rtl/amst_pkg.sv
`default_nettype none

package amst_pkg;

  localparam int unsigned WordW  = 16;
  localparam int unsigned CntAbsW = 14;
  localparam int unsigned MgW    = 12;
  localparam int unsigned MagW   = 12;
  localparam int unsigned CountW = 32;
  localparam int unsigned QuoW   = 11;
  localparam int unsigned ProdW  = 21;
  localparam int unsigned SqW    = 2 * QuoW;
  localparam int unsigned SumW   = 24;
  localparam int unsigned RemW   = 15;
  localparam int unsigned ShW    = MagW + 2;
  localparam int unsigned StepW  = 4;

  localparam int unsigned DivSteps  = QuoW;
  localparam int unsigned MulSteps  = QuoW + 1;
  localparam int unsigned SumSteps  = 2;
  localparam int unsigned SqrtSteps = SumW / 2;

  localparam logic [ProdW-1:0] MgScale  = ProdW'(244);
  localparam logic [ProdW-1:0] DivCmp   = ProdW'(1000 * 1024);
  localparam logic [MagW-1:0]  MagStart = MagW'(1000);
  localparam logic [MagW-1:0]  MagMax   = MagW'(3461);

  typedef struct packed {
    logic [WordW-1:0] x_word;
    logic [WordW-1:0] y_word;
    logic [WordW-1:0] z_word;
    logic             read_failed;
  } in_t;

  typedef struct packed {
    logic signed [MgW-1:0] x_milli_g;
    logic signed [MgW-1:0] y_milli_g;
    logic signed [MgW-1:0] z_milli_g;
    logic [MagW-1:0]       magnitude_milli_g;
    logic [MagW-1:0]       shock_level;
    logic [CountW-1:0]     sample_count;
    logic [CountW-1:0]     error_count;
  } out_t;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DIV  = 6'b000010,
    ST_MUL  = 6'b000100,
    ST_SUM  = 6'b001000,
    ST_SQRT = 6'b010000,
    ST_DONE = 6'b100000
  } state_e;

  typedef struct packed {
    logic load;
    logic div_step;
    logic mul_load;
    logic mul_step;
  } lane_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/accel_magnitude_shock_tracker_unit.sv
// Channel | Direction | Handshake                  | Payload
// in      | input     | in_valid_i / in_stall_o    | in_item_i  (in_t)
// out     | output    | out_valid_o / out_stall_i  | out_item_o (out_t)
//
// A good item passes from acceptance through bit-serial division by 1000, shift-add
// squaring, summing and the bit-pair square root to a registered result, then a state
// update. A failed read goes straight to that update.
// The input stalls until that update, so an item is finished before the next one is
// accepted; a stalled result holds the update back.
// Reset clears control state, held results and counters; prior magnitude starts at 1000.
// One item is in work at a time; a finished result waits in the output register
// while the next item is accepted.
`default_nettype none

module accel_magnitude_shock_tracker_unit import amst_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_item_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_item_o
);

  state_e            state_q, state_d;
  logic [StepW-1:0]  cnt_q,   cnt_d;
  logic              fail_q,  fail_d;
  lane_ctrl_t        ctrl;
  logic              in_fire;
  logic              out_free;
  logic              done_fire;

  logic signed [MgW-1:0] mg_x, mg_y, mg_z;
  logic [SqW-1:0]        sq_x, sq_y, sq_z;

  logic [SumW-1:0]   sum_q,  sum_d;
  logic [RemW-1:0]   rem_q,  rem_d;
  logic [MagW-1:0]   root_q, root_d;
  logic [RemW-1:0]   rem_sh;
  logic [RemW-1:0]   trial;

  logic [MagW-1:0]   mag_new;
  logic [MagW-1:0]   delta;
  logic [ShW-1:0]    sh_sum;

  logic signed [MgW-1:0] held_x_q, held_y_q, held_z_q;
  logic signed [MgW-1:0] held_x_d, held_y_d, held_z_d;
  logic [MagW-1:0]   held_mag_q, held_mag_d;
  logic [MagW-1:0]   prior_q,    prior_d;
  logic [MagW-1:0]   shock_q,    shock_d;
  logic [CountW-1:0] good_q,     good_d;
  logic [CountW-1:0] failed_q,   failed_d;

  logic              out_valid_q, out_valid_d;
  out_t              out_q,       out_d;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  amst_axis_lane u_lane_x (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .word_i    (in_item_i.x_word),
    .milli_g_o (mg_x),
    .square_o  (sq_x)
  );

  amst_axis_lane u_lane_y (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .word_i    (in_item_i.y_word),
    .milli_g_o (mg_y),
    .square_o  (sq_y)
  );

  amst_axis_lane u_lane_z (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .word_i    (in_item_i.z_word),
    .milli_g_o (mg_z),
    .square_o  (sq_z)
  );

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    fail_d    = fail_q;
    ctrl      = '0;
    done_fire = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          fail_d = in_item_i.read_failed;
          cnt_d  = '0;
          if (in_item_i.read_failed) begin
            state_d = ST_DONE;
          end else begin
            ctrl.load = 1'b1;
            state_d   = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        ctrl.div_step = 1'b1;
        cnt_d         = cnt_q + StepW'(1);
        if (cnt_q == StepW'(DivSteps - 1)) begin
          cnt_d   = '0;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (cnt_q == '0) begin
          ctrl.mul_load = 1'b1;
        end else begin
          ctrl.mul_step = 1'b1;
        end
        cnt_d = cnt_q + StepW'(1);
        if (cnt_q == StepW'(MulSteps - 1)) begin
          cnt_d   = '0;
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        cnt_d = cnt_q + StepW'(1);
        if (cnt_q == StepW'(SumSteps - 1)) begin
          cnt_d   = '0;
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        cnt_d = cnt_q + StepW'(1);
        if (cnt_q == StepW'(SqrtSteps - 1)) begin
          cnt_d   = '0;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          done_fire = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    sum_d  = sum_q;
    rem_d  = rem_q;
    root_d = root_q;
    rem_sh = {rem_q[RemW-3:0], sum_q[SumW-1 -: 2]};
    trial  = RemW'({root_q, 2'b01});
    if (state_q == ST_SUM) begin
      if (cnt_q == '0) begin
        sum_d = SumW'(sq_x) + SumW'(sq_y);
      end else begin
        sum_d  = sum_q + SumW'(sq_z);
        rem_d  = '0;
        root_d = '0;
      end
    end else if (state_q == ST_SQRT) begin
      sum_d = sum_q << 2;
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[MagW-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[MagW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    mag_new = root_q + MagW'(rem_q > RemW'(root_q));
    delta   = (mag_new >= prior_q) ? (mag_new - prior_q) : (prior_q - mag_new);
    sh_sum  = ShW'({shock_q, 1'b0}) + ShW'(shock_q) + ShW'(delta);

    held_x_d   = held_x_q;
    held_y_d   = held_y_q;
    held_z_d   = held_z_q;
    held_mag_d = held_mag_q;
    prior_d    = prior_q;
    shock_d    = shock_q;
    good_d     = good_q;
    failed_d   = failed_q;

    if (done_fire) begin
      if (fail_q) begin
        failed_d = failed_q + CountW'(1);
      end else begin
        held_x_d   = mg_x;
        held_y_d   = mg_y;
        held_z_d   = mg_z;
        held_mag_d = mag_new;
        prior_d    = mag_new;
        shock_d    = sh_sum[ShW-1:2];
        good_d     = good_q + CountW'(1);
      end
    end

    out_d                   = out_q;
    out_d.x_milli_g         = held_x_d;
    out_d.y_milli_g         = held_y_d;
    out_d.z_milli_g         = held_z_d;
    out_d.magnitude_milli_g = held_mag_d;
    out_d.shock_level       = shock_d;
    out_d.sample_count      = good_d;
    out_d.error_count       = failed_d;
    if (!done_fire) begin
      out_d = out_q;
    end

    out_valid_d = out_valid_q;
    if (done_fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      fail_q      <= 1'b0;
      held_x_q    <= '0;
      held_y_q    <= '0;
      held_z_q    <= '0;
      held_mag_q  <= '0;
      prior_q     <= MagStart;
      shock_q     <= '0;
      good_q      <= '0;
      failed_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      fail_q      <= fail_d;
      held_x_q    <= held_x_d;
      held_y_q    <= held_y_d;
      held_z_q    <= held_z_d;
      held_mag_q  <= held_mag_d;
      prior_q     <= prior_d;
      shock_q     <= shock_d;
      good_q      <= good_d;
      failed_q    <= failed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q  <= sum_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_rise_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("result appeared without a finished item");

  a_mag_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.magnitude_milli_g <= MagMax))
    else $error("magnitude out of range");

  a_fail_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_fire && fail_q) |=> (failed_q == $past(failed_q) + CountW'(1)) &&
                              (good_q == $past(good_q)))
    else $error("failed read did not count correctly");

  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !in_item_i.read_failed) |=> (state_q == ST_DIV) && in_stall_o)
    else $error("good item did not start division");

endmodule

`default_nettype wire

FILE: rtl/amst_axis_lane.sv
`default_nettype none

module amst_axis_lane import amst_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lane_ctrl_t            ctrl_i,
  input  logic [WordW-1:0]      word_i,
  output logic signed [MgW-1:0] milli_g_o,
  output logic [SqW-1:0]        square_o
);

  logic [CntAbsW-1:0] count_abs;
  logic [ProdW-1:0]   prod;
  logic               div_ge;

  logic               neg_q,  neg_d;
  logic [ProdW-1:0]   rem_q,  rem_d;
  logic [QuoW-1:0]    quo_q,  quo_d;
  logic [QuoW-1:0]    mplr_q, mplr_d;
  logic [SqW-1:0]     acc_q,  acc_d;
  logic               busy_q, busy_d;

  always_comb begin
    count_abs = word_i[WordW-1] ? CntAbsW'(-word_i[WordW-1:2]) : word_i[WordW-1:2];
    prod      = ProdW'(count_abs) * MgScale;
    div_ge    = rem_q >= DivCmp;

    neg_d  = neg_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    mplr_d = mplr_q;
    acc_d  = acc_q;
    busy_d = busy_q;

    if (ctrl_i.load) begin
      neg_d  = word_i[WordW-1];
      rem_d  = prod;
      quo_d  = '0;
      busy_d = 1'b1;
    end else if (ctrl_i.div_step) begin
      rem_d = div_ge ? ((rem_q - DivCmp) << 1) : (rem_q << 1);
      quo_d = {quo_q[QuoW-2:0], div_ge};
    end else if (ctrl_i.mul_load) begin
      mplr_d = quo_q;
      acc_d  = '0;
      busy_d = 1'b0;
    end else if (ctrl_i.mul_step) begin
      acc_d  = (acc_q << 1) + (mplr_q[QuoW-1] ? SqW'(quo_q) : SqW'(0));
      mplr_d = mplr_q << 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    mplr_q <= mplr_d;
    acc_q  <= acc_d;
  end

  assign milli_g_o = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
  assign square_o  = busy_q ? '0 : acc_q;

endmodule

`default_nettype wire
